FILE: sv/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types and constants of the lowest-free id allocator.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int unsigned ID_SPACE_DEF = 256;
    localparam int unsigned FIELD_W      = 8;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned WORD_SH      = 5;

    localparam logic [1:0] REQ_TAKE    = 2'd0;
    localparam logic [1:0] REQ_ADD     = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_QUERY   = 2'd3;

    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    localparam logic [FIELD_W-1:0] RANGE_LOW_RST  = 8'd1;
    localparam logic [FIELD_W-1:0] RANGE_HIGH_RST = 8'd255;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FIELD_W-1:0] id_in;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] granted_id;
        logic               ok;
        logic [FIELD_W-1:0] next_free;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP_WR,
        ST_SCAN
    } t_state;

endpackage

FILE: sv/lfa_ram.sv
// ----------------------------------------------------------------------------
// lfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lfa_find.sv
// ----------------------------------------------------------------------------
// lfa_find
// Lowest free bit of one bitmap word, confined to the effective id range.
// ----------------------------------------------------------------------------
module lfa_find import lfa_pkg::*; #(
    parameter int unsigned PW = 8
) (
    input  logic [WORD_W-1:0]     i_used,
    input  logic [PW-WORD_SH-1:0] i_widx,
    input  logic [PW-1:0]         i_lo,
    input  logic [PW-1:0]         i_hi,
    output logic                  o_found,
    output logic [PW-1:0]         o_id
);

    logic [WORD_W-1:0]  cand;
    logic [WORD_SH-1:0] low_bit;

    // a bit qualifies if free and inside the range on a boundary word
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            cand[j] = !i_used[j]
                && ((i_widx != i_lo[PW-1:WORD_SH]) || (WORD_SH'(j) >= i_lo[WORD_SH-1:0]))
                && ((i_widx != i_hi[PW-1:WORD_SH]) || (WORD_SH'(j) <= i_hi[WORD_SH-1:0]));
        end
    end

    always_comb begin
        low_bit = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                low_bit = WORD_SH'(j);
            end
        end
    end

    assign o_found = |cand;
    assign o_id    = {i_widx, low_bit};

endmodule

FILE: sv/lowest_free_id_allocator_core.sv
// Add/release/query act on the id's word, then scan word by word for the next free id;
// take scans up to the granted word, writes it, then rescans from that word (32 ids per
// word, one word read per cycle).
// Throughput: one request at a time; the next is taken in the cycle the result strobe shows.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset clears the per-word valid flags at once (no clearing pass) and restores the range.
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_core
// Bitmap id allocator: take, add, release and query with a word-serial
// lowest-free search through one shared find unit.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_core import lfa_pkg::*; #(
    parameter int unsigned ID_SPACE = ID_SPACE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  t_req               i_req,
    output logic               o_done,
    output t_rsp               o_rsp,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_wdata
);

    localparam int unsigned ID_W   = $clog2(ID_SPACE);
    localparam int unsigned RW     = ((ID_W > FIELD_W) ? ID_W : FIELD_W) + 1;
    localparam int unsigned NWORDS = (ID_SPACE + WORD_W - 1) / WORD_W;
    localparam int unsigned WI_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned PW     = WORD_SH + WI_W;
    localparam logic [RW-1:0] TOP   = RW'(ID_SPACE - 1);
    localparam logic [RW-1:0] SPACE = RW'(ID_SPACE);

    // configuration
    logic [FIELD_W-1:0] r_range_low;
    logic [FIELD_W-1:0] r_range_high;

    // sequencer state
    t_state          r_state, n_state;
    logic [1:0]      r_req_type, n_req_type;
    logic [PW-1:0]   r_pid, n_pid;
    logic            r_id_ok, n_id_ok;
    logic            r_take, n_take;
    logic [WI_W-1:0] r_rd_word, n_rd_word;
    logic [WI_W-1:0] r_chk_word, n_chk_word;
    logic            r_chk_vld, n_chk_vld;
    logic [PW-1:0]   r_granted, n_granted;
    logic            r_ok, n_ok;
    logic            r_done, n_done;
    t_rsp            r_out, n_out;
    logic [NWORDS-1:0] r_wvld;
    logic            r_rd_vld;

    // effective range
    logic [RW-1:0]   l_eff, h_raw, h_eff;
    logic            rng_empty;
    logic [PW-1:0]   lo, hi;
    logic [WI_W-1:0] lo_word, hi_word;

    // request decode
    logic [RW-1:0]   id_ext;
    logic [PW-1:0]   pid_in;

    // memory and find unit
    logic              ram_we;
    logic [WI_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata, used;
    logic              fnd_found;
    logic [PW-1:0]     fnd_id;
    logic              held;

    assign l_eff     = (r_range_low == '0) ? RW'(1) : RW'(r_range_low);
    assign h_raw     = (RW'(r_range_high) <= l_eff) ? l_eff + RW'(1) : RW'(r_range_high);
    assign h_eff     = (h_raw > TOP) ? TOP : h_raw;
    assign rng_empty = l_eff > h_eff;
    assign lo        = l_eff[PW-1:0];
    assign hi        = h_eff[PW-1:0];
    assign lo_word   = lo[PW-1:WORD_SH];
    assign hi_word   = hi[PW-1:WORD_SH];

    assign id_ext = RW'(i_req.id_in);
    assign pid_in = id_ext[PW-1:0];

    // words never written read as clear
    assign used = r_rd_vld ? ram_rdata : '0;
    assign held = used[r_pid[WORD_SH-1:0]];

    assign ram_raddr = (r_state == ST_IDLE) ? pid_in[PW-1:WORD_SH] : r_rd_word;

    lfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lfa_find #(
        .PW (PW)
    ) u_find (
        .i_used  (used),
        .i_widx  (r_chk_word),
        .i_lo    (lo),
        .i_hi    (hi),
        .o_found (fnd_found),
        .o_id    (fnd_id)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_wdata;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_done    <= 1'b0;
            r_chk_vld <= 1'b0;
            r_wvld    <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_chk_vld <= n_chk_vld;
            r_rd_vld  <= (ram_raddr <= WI_W'(NWORDS - 1)) ? r_wvld[ram_raddr] : 1'b0;
            if (ram_we) begin
                r_wvld[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_pid      <= n_pid;
        r_id_ok    <= n_id_ok;
        r_take     <= n_take;
        r_rd_word  <= n_rd_word;
        r_chk_word <= n_chk_word;
        r_granted  <= n_granted;
        r_ok       <= n_ok;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_req_type = r_req_type;
        n_pid      = r_pid;
        n_id_ok    = r_id_ok;
        n_take     = r_take;
        n_rd_word  = r_rd_word;
        n_chk_word = r_chk_word;
        n_chk_vld  = r_chk_vld;
        n_granted  = r_granted;
        n_ok       = r_ok;
        n_done     = 1'b0;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_pid[PW-1:WORD_SH];
        ram_wdata  = used;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req_type = i_req.req_type;
                    n_pid      = pid_in;
                    n_id_ok    = id_ext < SPACE;
                    n_granted  = '0;
                    n_ok       = 1'b0;
                    n_chk_vld  = 1'b0;
                    if (i_req.req_type == REQ_TAKE) begin
                        if (rng_empty) begin
                            n_done = 1'b1;
                            n_out  = '0;
                        end else begin
                            n_state   = ST_SCAN;
                            n_take    = 1'b1;
                            n_rd_word = lo_word;
                        end
                    end else begin
                        // word of the id is being read now
                        n_state = ST_OP_WR;
                        n_take  = 1'b0;
                    end
                end
            end

            ST_OP_WR: begin
                ram_waddr = r_pid[PW-1:WORD_SH];
                case (r_req_type)
                    REQ_ADD: begin
                        if (r_id_ok && !held) begin
                            ram_we    = 1'b1;
                            ram_wdata = used | (WORD_W'(1) << r_pid[WORD_SH-1:0]);
                            n_ok      = 1'b1;
                        end
                    end
                    REQ_RELEASE: begin
                        if (r_id_ok && held) begin
                            ram_we    = 1'b1;
                            ram_wdata = used & ~(WORD_W'(1) << r_pid[WORD_SH-1:0]);
                            n_ok      = 1'b1;
                        end
                    end
                    default: begin
                        n_ok = r_id_ok && held;
                    end
                endcase
                if (rng_empty) begin
                    n_state          = ST_IDLE;
                    n_done           = 1'b1;
                    n_out.granted_id = '0;
                    n_out.ok         = n_ok;
                    n_out.next_free  = '0;
                end else begin
                    n_state   = ST_SCAN;
                    n_rd_word = lo_word;
                    n_chk_vld = 1'b0;
                end
            end

            ST_SCAN: begin
                // read one word ahead, check the word read last cycle
                n_rd_word  = r_rd_word + WI_W'(1);
                n_chk_word = r_rd_word;
                n_chk_vld  = 1'b1;
                if (r_chk_vld) begin
                    if (fnd_found && r_take) begin
                        ram_we     = 1'b1;
                        ram_waddr  = r_chk_word;
                        ram_wdata  = used | (WORD_W'(1) << fnd_id[WORD_SH-1:0]);
                        n_granted  = fnd_id;
                        n_ok       = 1'b1;
                        n_take     = 1'b0;
                        // rescan from the granted word for the next free id
                        n_rd_word  = r_chk_word;
                        n_chk_vld  = 1'b0;
                    end else if (fnd_found || r_chk_word == hi_word) begin
                        n_state          = ST_IDLE;
                        n_done           = 1'b1;
                        n_chk_vld        = 1'b0;
                        n_out.granted_id = FIELD_W'(r_granted);
                        n_out.ok         = r_ok;
                        n_out.next_free  = fnd_found ? FIELD_W'(fnd_id) : '0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_out;

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.granted_id != '0)) |-> o_rsp.ok)
        else $error("granted id without ok");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_chk_vld) |-> (r_chk_word >= lo_word && r_chk_word <= hi_word))
        else $error("scan outside the id range");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_OP_WR || r_state == ST_SCAN))
        else $error("bitmap written outside a request");

    a_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_busy)) |-> o_done)
        else $error("request finished without result strobe");

endmodule

FILE: tb/sv/lowest_free_id_allocator_core_test.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_core_test
// Self-checking bench for the lowest-free id allocator. Requests go in one at
// a time through the start/busy handshake. A bitmap mirror works out each
// result, and every strobed result is checked against the oldest outstanding
// expectation. The run covers directed corner cases, several range settings
// including the extremes, a fill of the whole id space, and a random tail
// with no idle cycles.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_core_test import lfa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_SPACE    = ID_SPACE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_req               i_req;
    logic               o_done;
    t_rsp               o_rsp;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [FIELD_W-1:0] i_cfg_wdata;

    // mirror of the allocator state
    bit [ID_SPACE-1:0]  used_ids;
    logic [FIELD_W-1:0] range_low_q;
    logic [FIELD_W-1:0] range_high_q;

    t_rsp pending_rsp_q[$];

    int cycle_count;
    int mismatches;
    int requests_sent;
    int results_checked;
    int grants_seen;
    int takes_refused;
    int range_settings;
    bit idle_on;

    lowest_free_id_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void grant_bounds(output int lo, output int hi);
        lo = (range_low_q == '0) ? 1 : int'(range_low_q);
        hi = int'(range_high_q);
        if (hi <= lo) hi = lo + 1;
        if (hi > ID_SPACE - 1) hi = ID_SPACE - 1;
    endfunction

    function automatic int lowest_free_id();
        int lo;
        int hi;
        grant_bounds(lo, hi);
        for (int i = lo; i <= hi; i++) begin
            if (!used_ids[i]) return i;
        end
        return 0;
    endfunction

    function automatic t_rsp apply_request(t_req req);
        t_rsp rsp;
        int   id;
        int   grant;
        rsp = '0;
        id  = int'(req.id_in);
        case (req.req_type)
            REQ_TAKE: begin
                grant = lowest_free_id();
                if (grant != 0) begin
                    used_ids[grant] = 1'b1;
                    rsp.granted_id  = grant[FIELD_W-1:0];
                    rsp.ok          = 1'b1;
                    grants_seen++;
                end else begin
                    takes_refused++;
                end
            end
            REQ_ADD: begin
                if (id < ID_SPACE && !used_ids[id]) begin
                    used_ids[id] = 1'b1;
                    rsp.ok       = 1'b1;
                end
            end
            REQ_RELEASE: begin
                if (id < ID_SPACE && used_ids[id]) begin
                    used_ids[id] = 1'b0;
                    rsp.ok       = 1'b1;
                end
            end
            default: begin
                rsp.ok = (id < ID_SPACE) && used_ids[id];
            end
        endcase
        grant         = lowest_free_id();
        rsp.next_free = grant[FIELD_W-1:0];
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0d] result with no request outstanding: %p", cycle_count, o_rsp);
            end else begin
                want = pending_rsp_q.pop_front();
                results_checked++;
                if (o_rsp.granted_id !== want.granted_id || o_rsp.ok !== want.ok ||
                    o_rsp.next_free !== want.next_free) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0d] grant/ok/next expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 cycle_count, want.granted_id, want.ok, want.next_free,
                                 o_rsp.granted_id, o_rsp.ok, o_rsp.next_free);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_request(input t_req req);
        t_rsp exp_rsp;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_busy);
        exp_rsp       = apply_request(req);
        pending_rsp_q = {pending_rsp_q, exp_rsp};
        requests_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input int id);
        t_req req;
        req.req_type = op;
        req.id_in    = id[FIELD_W-1:0];
        send_request(req);
    endtask

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                i_start <= 1'b0;
            end
        end
    endtask

    // hold until every outstanding result has come back
    task automatic wait_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [FIELD_W-1:0] value);
        @(negedge i_clk);
        i_start     <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_RANGE_LOW) range_low_q = value;
        else range_high_q = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_range(input int lo, input int hi);
        wait_results();
        write_cfg(CFG_RANGE_LOW, lo[FIELD_W-1:0]);
        write_cfg(CFG_RANGE_HIGH, hi[FIELD_W-1:0]);
        range_settings++;
    endtask

    // mostly ids inside the grant range, some at the edges, the rest anywhere
    function automatic t_req random_request();
        t_req req;
        int   lo;
        int   hi;
        int   roll;
        grant_bounds(lo, hi);
        roll = $urandom_range(0, 99);
        if (roll < 35)      req.req_type = REQ_TAKE;
        else if (roll < 50) req.req_type = REQ_ADD;
        else if (roll < 80) req.req_type = REQ_RELEASE;
        else                req.req_type = REQ_QUERY;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            req.id_in = FIELD_W'($urandom_range(lo, hi));
        end else if (roll < 70) begin
            case ($urandom_range(0, 3))
                0:       req.id_in = '0;
                1:       req.id_in = '1;
                2:       req.id_in = FIELD_W'(lo - 1);
                default: req.id_in = FIELD_W'(hi + 1);
            endcase
        end else begin
            req.id_in = FIELD_W'($urandom_range(0, ID_SPACE - 1));
        end
        return req;
    endfunction

    task automatic random_burst(input int count);
        for (int n = 0; n < count; n++) begin
            idle_gap();
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic run_reset();
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_RANGE_LOW;
        i_cfg_wdata  = '0;
        used_ids     = '0;
        range_low_q  = RANGE_LOW_RST;
        range_high_q = RANGE_HIGH_RST;
        idle_on      = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_directed_edges();
        send_op(REQ_QUERY, 1);
        send_op(REQ_TAKE, 8'hFF);
        send_op(REQ_TAKE, 0);
        send_op(REQ_ADD, 0);
        send_op(REQ_ADD, 0);
        send_op(REQ_QUERY, 0);
        send_op(REQ_RELEASE, 0);
        send_op(REQ_RELEASE, 0);
        send_op(REQ_QUERY, 0);
        send_op(REQ_ADD, 8'hFF);
        send_op(REQ_QUERY, 8'hFF);
        send_op(REQ_ADD, 1);
        send_op(REQ_RELEASE, 1);
        send_op(REQ_TAKE, 8'h55);
        send_op(REQ_ADD, 8'hAA);
        send_op(REQ_QUERY, 8'hAA);
        send_op(REQ_RELEASE, 8'h55);
        send_op(REQ_RELEASE, 8'hAA);
        send_op(REQ_RELEASE, 8'hFF);
        send_op(REQ_QUERY, 8'h55);
    endtask

    task automatic test_range_settings();
        int lows[10]  = '{0, 255, 255, 10, 200, 128, 0, 37, 254, 1};
        int highs[10] = '{0, 255, 0, 5, 203, 128, 255, 40, 255, 8};
        for (int s = 0; s < 10; s++) begin
            set_range(lows[s], highs[s]);
            idle_on = ($urandom_range(0, 3) != 0);
            random_burst(35);
            // once per setting, let everything drain mid-burst
            wait_results();
            random_burst(35);
        end
        set_range($urandom_range(0, 255), $urandom_range(0, 255));
        random_burst(60);
    endtask

    task automatic test_fill_whole_space();
        set_range(1, 255);
        idle_on = 1'b0;
        for (int n = 0; n < 260; n++) send_op(REQ_TAKE, $urandom_range(0, 255));
        idle_on = 1'b1;
        for (int n = 0; n < 20; n++) begin
            idle_gap();
            send_op(REQ_RELEASE, $urandom_range(1, 255));
            send_op(REQ_TAKE, 0);
        end
    endtask

    task automatic test_random_tail();
        set_range($urandom_range(1, 64), $urandom_range(96, 255));
        idle_on = 1'b0;
        random_burst(100);
    endtask

    initial begin
        run_reset();
        test_directed_edges();
        test_range_settings();
        test_fill_whole_space();
        test_random_tail();
        wait_results();
        repeat (40) @(posedge i_clk);
        if (pending_rsp_q.size() != 0) begin
            mismatches += pending_rsp_q.size();
            $display("%0d results never arrived", pending_rsp_q.size());
        end
        $display("Covered %0d requests over %0d range settings: %0d grants, %0d takes refused.",
                 requests_sent, range_settings, grants_seen, takes_refused);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
